FILE: rtl/hpq_pkg.sv
// Shared constants, types and microcode field codes for the max-heap priority queue.
// No dependencies; every other file refers to this package by scoped names.
package hpq_pkg;

	localparam int unsigned DEPTH  = 1024;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = ADDR_W + 1;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned UPC_W  = 4;

	// request action codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [UPC_W-1:0]  upc_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// read port source
	typedef enum logic [2:0] {
		RD_NONE,
		RD_PARENT,
		RD_LEFT,
		RD_RIGHT,
		RD_ROOT,
		RD_LAST
	} rd_t;

	// datapath register/write action
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_PUSH_INIT,
		ACT_MOVE_UP,
		ACT_PUT_VAL,
		ACT_TAKE_TOP,
		ACT_POP_INIT,
		ACT_KEEP_LEFT,
		ACT_MOVE_DOWN,
		ACT_SET_FULL,
		ACT_SET_EMPTY,
		ACT_OUT
	} act_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_NO_IN,
		C_POP,
		C_FULL,
		C_AT_ROOT,
		C_NOT_LESS,
		C_EMPTY,
		C_NO_CHILD,
		C_NOT_LESS_CHILD,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		rd_t   rd;
		act_t  act;
		logic  gated;   // action only when the jump is not taken
		cond_t cond;
		upc_t  target;
		upc_t  nxt;
	} ucode_t;

	typedef struct packed {
		rd_t  rd;
		act_t act;
	} ctl_t;

	typedef struct packed {
		logic pop;
		logic full;
		logic at_root;
		logic not_less;
		logic empty;
		logic no_child;
		logic not_less_child;
		logic out_busy;
	} flags_t;

	// program addresses
	localparam upc_t S_WAIT      = 4'd0;
	localparam upc_t S_DISPATCH  = 4'd1;
	localparam upc_t S_PUSH      = 4'd2;
	localparam upc_t S_PUSH_INIT = 4'd3;
	localparam upc_t S_UP_RD     = 4'd4;
	localparam upc_t S_UP_CMP    = 4'd5;
	localparam upc_t S_PUT       = 4'd6;
	localparam upc_t S_POP       = 4'd7;
	localparam upc_t S_POP_LAST  = 4'd8;
	localparam upc_t S_POP_INIT  = 4'd9;
	localparam upc_t S_DN_RD     = 4'd10;
	localparam upc_t S_DN_RIGHT  = 4'd11;
	localparam upc_t S_DN_CMP    = 4'd12;
	localparam upc_t S_FULL      = 4'd13;
	localparam upc_t S_EMPTY     = 4'd14;
	localparam upc_t S_FIN       = 4'd15;

endpackage

FILE: rtl/hpq_if.sv
// Request and response channel interfaces for the max-heap priority queue.
// Depends on hpq_pkg for payload widths.
interface hpq_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [hpq_pkg::DATA_W-1:0]  value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface hpq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [hpq_pkg::DATA_W-1:0]  top_value;
	logic [1:0]                  status;
	logic [hpq_pkg::CNT_W-1:0]   count;

	modport source (output valid, output top_value, output status, output count, input ready);
	modport sink   (input valid, input top_value, input status, input count, output ready);
endinterface

FILE: rtl/max_heap_priority_queue.sv
// Max-heap priority queue: one result word per request word, in order.
// A push climbs 0..10 levels and a pop descends 0..9 levels; a push to a full heap or a
// pop from an empty one is refused with a status. One word is taken at a time: the next
// only once the last result is in the output register, which waits for the one before it.
// The store is used as one port: each sequencer step does at most one read or one write.
// Reset clears the count, sequencer and output valid; store contents need no clearing.
module max_heap_priority_queue (
	input  logic clk,
	input  logic arst_n,
	hpq_req_if.sink   req,
	hpq_rsp_if.source rsp
);

	hpq_pkg::ctl_t   ctl;
	hpq_pkg::flags_t flags;
	logic            in_ready;
	logic            fire;

	assign req.ready = in_ready;
	assign fire      = req.valid && in_ready;

	hpq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.flags    (flags),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	hpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.action    (req.action),
		.value     (req.value),
		.rsp_ready (rsp.ready),
		.flags     (flags),
		.rsp_valid (rsp.valid),
		.top_value (rsp.top_value),
		.status    (rsp.status),
		.count     (rsp.count)
	);

endmodule

FILE: rtl/hpq_seq.sv
// Microcode sequencer: step counter, program ROM and jump condition select.
// Depends on hpq_pkg; drives the datapath in hpq_dp.
module hpq_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  hpq_pkg::flags_t flags,
	output hpq_pkg::ctl_t   ctl,
	output logic            in_ready
);

	hpq_pkg::upc_t   upc_q;
	hpq_pkg::upc_t   upc_d;
	hpq_pkg::ucode_t uw;
	logic            hit;

	function automatic hpq_pkg::ucode_t mk(hpq_pkg::rd_t rd, hpq_pkg::act_t act, logic gated,
			hpq_pkg::cond_t cond, hpq_pkg::upc_t target, hpq_pkg::upc_t nxt);
		hpq_pkg::ucode_t w;
		w.rd     = rd;
		w.act    = act;
		w.gated  = gated;
		w.cond   = cond;
		w.target = target;
		w.nxt    = nxt;
		return w;
	endfunction

	function automatic hpq_pkg::ucode_t rom(hpq_pkg::upc_t a);
		hpq_pkg::ucode_t w;
		unique case (a)
			hpq_pkg::S_WAIT:      w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_LATCH, 1'b1,
				hpq_pkg::C_NO_IN, hpq_pkg::S_WAIT, hpq_pkg::S_DISPATCH);
			hpq_pkg::S_DISPATCH:  w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_POP, hpq_pkg::S_POP, hpq_pkg::S_PUSH);
			hpq_pkg::S_PUSH:      w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_FULL, hpq_pkg::S_FULL, hpq_pkg::S_PUSH_INIT);
			hpq_pkg::S_PUSH_INIT: w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_PUSH_INIT, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_UP_RD);
			hpq_pkg::S_UP_RD:     w = mk(hpq_pkg::RD_PARENT, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_AT_ROOT, hpq_pkg::S_PUT, hpq_pkg::S_UP_CMP);
			hpq_pkg::S_UP_CMP:    w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_MOVE_UP, 1'b1,
				hpq_pkg::C_NOT_LESS, hpq_pkg::S_PUT, hpq_pkg::S_UP_RD);
			hpq_pkg::S_PUT:       w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_PUT_VAL, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_FIN);
			hpq_pkg::S_POP:       w = mk(hpq_pkg::RD_ROOT, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_EMPTY, hpq_pkg::S_EMPTY, hpq_pkg::S_POP_LAST);
			hpq_pkg::S_POP_LAST:  w = mk(hpq_pkg::RD_LAST, hpq_pkg::ACT_TAKE_TOP, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_POP_INIT);
			hpq_pkg::S_POP_INIT:  w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_POP_INIT, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_DN_RD);
			hpq_pkg::S_DN_RD:     w = mk(hpq_pkg::RD_LEFT, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_NO_CHILD, hpq_pkg::S_PUT, hpq_pkg::S_DN_RIGHT);
			hpq_pkg::S_DN_RIGHT:  w = mk(hpq_pkg::RD_RIGHT, hpq_pkg::ACT_KEEP_LEFT, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_DN_CMP);
			hpq_pkg::S_DN_CMP:    w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_MOVE_DOWN, 1'b1,
				hpq_pkg::C_NOT_LESS_CHILD, hpq_pkg::S_PUT, hpq_pkg::S_DN_RD);
			hpq_pkg::S_FULL:      w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_SET_FULL, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_FIN);
			hpq_pkg::S_EMPTY:     w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_SET_EMPTY, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_FIN);
			hpq_pkg::S_FIN:       w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_OUT, 1'b1,
				hpq_pkg::C_OUT_BUSY, hpq_pkg::S_FIN, hpq_pkg::S_WAIT);
			default:              w = mk(hpq_pkg::RD_NONE, hpq_pkg::ACT_NONE, 1'b0,
				hpq_pkg::C_NEVER, hpq_pkg::S_WAIT, hpq_pkg::S_WAIT);
		endcase
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= hpq_pkg::S_WAIT;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		uw = rom(upc_q);
		unique case (uw.cond)
			hpq_pkg::C_NEVER:          hit = 1'b0;
			hpq_pkg::C_NO_IN:          hit = !fire;
			hpq_pkg::C_POP:            hit = flags.pop;
			hpq_pkg::C_FULL:           hit = flags.full;
			hpq_pkg::C_AT_ROOT:        hit = flags.at_root;
			hpq_pkg::C_NOT_LESS:       hit = flags.not_less;
			hpq_pkg::C_EMPTY:          hit = flags.empty;
			hpq_pkg::C_NO_CHILD:       hit = flags.no_child;
			hpq_pkg::C_NOT_LESS_CHILD: hit = flags.not_less_child;
			hpq_pkg::C_OUT_BUSY:       hit = flags.out_busy;
			default:                   hit = 1'b0;
		endcase
		upc_d   = hit ? uw.target : uw.nxt;
		ctl.rd  = uw.rd;
		ctl.act = (uw.gated && hit) ? hpq_pkg::ACT_NONE : uw.act;
	end

	assign in_ready = (upc_q == hpq_pkg::S_WAIT);

endmodule

FILE: rtl/hpq_dp.sv
// Heap datapath: entry store, index and value registers, comparators and output register.
// Depends on hpq_pkg; controlled by hpq_seq.
module hpq_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hpq_pkg::ctl_t               ctl,
	input  logic                        action,
	input  logic [hpq_pkg::DATA_W-1:0]  value,
	input  logic                        rsp_ready,
	output hpq_pkg::flags_t             flags,
	output logic                        rsp_valid,
	output logic [hpq_pkg::DATA_W-1:0]  top_value,
	output logic [1:0]                  status,
	output logic [hpq_pkg::CNT_W-1:0]   count
);

	hpq_pkg::data_t mem_q [hpq_pkg::DEPTH];
	hpq_pkg::data_t rdata_q;
	hpq_pkg::data_t val_q;
	hpq_pkg::data_t top_q;
	hpq_pkg::data_t child_q;
	hpq_pkg::cnt_t  pos_q;
	hpq_pkg::cnt_t  cnt_q;
	logic           act_q;
	hpq_pkg::status_t status_q;

	logic                       out_valid_q;
	hpq_pkg::data_t             out_top_q;
	hpq_pkg::status_t           out_status_q;
	hpq_pkg::cnt_t              out_cnt_q;

	logic [hpq_pkg::CNT_W:0]    left_idx;
	logic [hpq_pkg::CNT_W:0]    right_idx;
	logic [hpq_pkg::CNT_W:0]    rd_idx;
	logic [hpq_pkg::CNT_W:0]    rd_off;
	hpq_pkg::cnt_t              wr_off;
	logic                       has_right;
	logic                       use_right;
	hpq_pkg::data_t             eff_child;
	hpq_pkg::cnt_t              eff_pick;
	logic                       wr_en;
	hpq_pkg::data_t             wr_data;

	function automatic logic slt(hpq_pkg::data_t a, hpq_pkg::data_t b);
		return $signed(a) < $signed(b);
	endfunction

	assign left_idx  = {pos_q, 1'b0};
	assign right_idx = {pos_q, 1'b1};
	assign has_right = right_idx <= {1'b0, cnt_q};
	assign use_right = has_right && slt(child_q, rdata_q);
	assign eff_child = use_right ? rdata_q : child_q;
	assign eff_pick  = use_right ? right_idx[hpq_pkg::CNT_W-1:0] : left_idx[hpq_pkg::CNT_W-1:0];

	always_comb begin
		case (ctl.rd)
			hpq_pkg::RD_PARENT: rd_idx = {2'b00, pos_q[hpq_pkg::CNT_W-1:1]};
			hpq_pkg::RD_LEFT:   rd_idx = left_idx;
			hpq_pkg::RD_RIGHT:  rd_idx = right_idx;
			hpq_pkg::RD_LAST:   rd_idx = {1'b0, cnt_q};
			default:            rd_idx = (hpq_pkg::CNT_W+1)'(1);
		endcase
		rd_off = rd_idx - (hpq_pkg::CNT_W+1)'(1);
		wr_off = pos_q - hpq_pkg::CNT_W'(1);
		wr_en   = 1'b1;
		case (ctl.act)
			hpq_pkg::ACT_MOVE_UP:   wr_data = rdata_q;
			hpq_pkg::ACT_PUT_VAL:   wr_data = val_q;
			hpq_pkg::ACT_MOVE_DOWN: wr_data = eff_child;
			default: begin
				wr_data = val_q;
				wr_en   = 1'b0;
			end
		endcase
	end

	// store is 1-based in the index registers, 0-based in the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_off[hpq_pkg::ADDR_W-1:0]] <= wr_data;
		end
		if (ctl.rd != hpq_pkg::RD_NONE) begin
			rdata_q <= mem_q[rd_off[hpq_pkg::ADDR_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctl.act)
			hpq_pkg::ACT_LATCH: begin
				act_q    <= action;
				val_q    <= value;
				top_q    <= '0;
				status_q <= hpq_pkg::ST_OK;
			end
			hpq_pkg::ACT_PUSH_INIT: pos_q <= cnt_q + hpq_pkg::CNT_W'(1);
			hpq_pkg::ACT_MOVE_UP:   pos_q <= {1'b0, pos_q[hpq_pkg::CNT_W-1:1]};
			hpq_pkg::ACT_TAKE_TOP:  top_q <= rdata_q;
			hpq_pkg::ACT_POP_INIT: begin
				val_q <= rdata_q;
				pos_q <= hpq_pkg::CNT_W'(1);
			end
			hpq_pkg::ACT_KEEP_LEFT: child_q  <= rdata_q;
			hpq_pkg::ACT_MOVE_DOWN: pos_q    <= eff_pick;
			hpq_pkg::ACT_SET_FULL:  status_q <= hpq_pkg::ST_FULL;
			hpq_pkg::ACT_SET_EMPTY: status_q <= hpq_pkg::ST_EMPTY;
			hpq_pkg::ACT_OUT: begin
				out_top_q    <= top_q;
				out_status_q <= status_q;
				out_cnt_q    <= cnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.act == hpq_pkg::ACT_PUSH_INIT) begin
				cnt_q <= cnt_q + hpq_pkg::CNT_W'(1);
			end else if (ctl.act == hpq_pkg::ACT_POP_INIT) begin
				cnt_q <= cnt_q - hpq_pkg::CNT_W'(1);
			end
			if (ctl.act == hpq_pkg::ACT_OUT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		flags.pop            = (act_q == hpq_pkg::OP_POP);
		flags.full           = (cnt_q == hpq_pkg::CNT_W'(hpq_pkg::DEPTH));
		flags.at_root        = (pos_q == hpq_pkg::CNT_W'(1));
		flags.not_less       = !slt(rdata_q, val_q);
		flags.empty          = (cnt_q == '0);
		flags.no_child       = left_idx > {1'b0, cnt_q};
		flags.not_less_child = !slt(val_q, eff_child);
		flags.out_busy       = out_valid_q && !rsp_ready;
	end

	assign rsp_valid = out_valid_q;
	assign top_value = out_top_q;
	assign status    = out_status_q;
	assign count     = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hpq_pkg::CNT_W'(hpq_pkg::DEPTH))
		else $error("entry count beyond depth");

	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.act == hpq_pkg::ACT_PUSH_INIT |=> cnt_q == $past(cnt_q) + hpq_pkg::CNT_W'(1))
		else $error("push did not bump count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == hpq_pkg::ACT_OUT && status_q == hpq_pkg::ST_FULL)
		|-> cnt_q == hpq_pkg::CNT_W'(hpq_pkg::DEPTH))
		else $error("full refusal with room left");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == hpq_pkg::ACT_OUT && status_q == hpq_pkg::ST_EMPTY)
		|-> (cnt_q == '0 && top_q == '0))
		else $error("empty refusal with entries held");

	a_move_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == hpq_pkg::ACT_MOVE_UP || ctl.act == hpq_pkg::ACT_MOVE_DOWN
			|| ctl.act == hpq_pkg::ACT_PUT_VAL) |-> pos_q != '0)
		else $error("store write at null index");

endmodule

FILE: test/hpq_checker.sv
// Scoreboard for the max-heap priority queue: watches both channels, keeps a shadow heap
// and compares every response word against it. Depends on hpq_pkg and hpq_if.sv.
module hpq_checker (
	input  logic clk,
	input  logic arst_n,
	hpq_req_if   req,
	hpq_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		hpq_pkg::data_t   top_value;
		hpq_pkg::status_t status;
		hpq_pkg::cnt_t    count;
	} heap_result_t;

	logic signed [hpq_pkg::DATA_W-1:0] shadow_heap [1:hpq_pkg::DEPTH];
	int unsigned                       shadow_size;
	heap_result_t                      due_results [$];

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic signed [hpq_pkg::DATA_W-1:0] t;
		t = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = t;
	endfunction

	// Applies one request word to the shadow heap and returns the response it should cause.
	function automatic heap_result_t apply_heap_op(logic op, hpq_pkg::data_t val);
		heap_result_t r;
		int unsigned  pos, lc, pick;
		logic         done;
		r.top_value = '0;
		r.status    = hpq_pkg::ST_OK;
		if (op == hpq_pkg::OP_PUSH) begin
			if (shadow_size >= hpq_pkg::DEPTH) begin
				r.status = hpq_pkg::ST_FULL;
			end else begin
				shadow_size++;
				shadow_heap[shadow_size] = val;
				pos  = shadow_size;
				done = 1'b0;
				while (pos > 1 && !done) begin
					if (shadow_heap[pos >> 1] < shadow_heap[pos]) begin
						swap_entries(pos >> 1, pos);
						pos = pos >> 1;
					end else begin
						done = 1'b1;
					end
				end
			end
		end else begin
			if (shadow_size == 0) begin
				r.status = hpq_pkg::ST_EMPTY;
			end else begin
				r.top_value = shadow_heap[1];
				shadow_heap[1] = shadow_heap[shadow_size];
				shadow_size--;
				pos  = 1;
				done = 1'b0;
				while (pos * 2 <= shadow_size && !done) begin
					lc   = pos * 2;
					pick = lc;
					// left child wins ties
					if (lc + 1 <= shadow_size && shadow_heap[lc] < shadow_heap[lc + 1])
						pick = lc + 1;
					if (shadow_heap[pos] < shadow_heap[pick]) begin
						swap_entries(pos, pick);
						pos = pick;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		r.count = hpq_pkg::cnt_t'(shadow_size);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want, seen;
		if (!arst_n) begin
			shadow_size = 0;
			due_results.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (req.valid && req.ready)
				due_results.push_back(apply_heap_op(req.action, req.value));
			if (rsp.valid && rsp.ready) begin
				seen.top_value = rsp.top_value;
				seen.status    = hpq_pkg::status_t'(rsp.status);
				seen.count     = rsp.count;
				if (due_results.size() == 0) begin
					if (fail_count < 10)
						$display("%t unexpected word: top=%0d st=%0d cnt=%0d",
							$realtime, $signed(seen.top_value), seen.status, seen.count);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (want != seen) begin
						if (fail_count < 10)
							$display("%t exp top=%0d st=%0d cnt=%0d, got top=%0d st=%0d cnt=%0d",
								$realtime, $signed(want.top_value), want.status, want.count,
								$signed(seen.top_value), seen.status, seen.count);
						fail_count++;
					end
				end
			end
			outstanding = due_results.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Top of the heap queue testbench: clock, reset, request stimulus, response back-pressure,
// watchdog and verdict. Depends on hpq_pkg, hpq_if.sv, hpq_checker and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   IDLE_LIMIT = 2000;
	localparam int   RAND_WORDS = 700;

	typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKED} rx_mode_t;
	typedef enum int {TR_GROW, TR_SHRINK, TR_EVEN} trend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   chk_fails;
	int   chk_outstanding;
	int   idle_run;
	int   burst_left;
	int   fill_level;

	always #5 clk = ~clk;

	hpq_req_if req_ch ();
	hpq_rsp_if rsp_ch ();

	max_heap_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hpq_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (chk_fails),
		.outstanding (chk_outstanding)
	);

	// Values lean towards the extremes and a narrow band so ties are common.
	function automatic hpq_pkg::data_t pick_value();
		hpq_pkg::data_t v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			1, 2: v = hpq_pkg::data_t'(int'($urandom_range(0, 7)) - 4);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Sends one word; called and returns just after a falling edge.
	task automatic send_word(input logic op, input hpq_pkg::data_t val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid  <= 1'b1;
		req_ch.action <= op;
		req_ch.value  <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (op == hpq_pkg::OP_PUSH && fill_level < hpq_pkg::DEPTH)
			fill_level++;
		else if (op == hpq_pkg::OP_POP && fill_level > 0)
			fill_level--;
	endtask

	task automatic drain_all();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		wait (chk_outstanding == 0);
		repeat (60) @(negedge clk);
		burst_left = 0;
	endtask

	// receiver back-pressure
	initial begin
		rx_mode_t    mode;
		int          span;
		logic [7:0]  pattern;
		rsp_ch.ready = 1'b0;
		forever begin
			mode    = rx_mode_t'($urandom_range(0, 3));
			span    = $urandom_range(8, 64);
			pattern = 8'($urandom) | 8'h01;
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:    rsp_ch.ready <= 1'b1;
					RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: rsp_ch.ready <= pattern[3'(i)];
					default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_run <= 0;
			end else if (idle_run >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	initial begin
		trend_t trend;
		logic   op;
		int     pct_push;
		req_ch.valid  = 1'b0;
		req_ch.action = hpq_pkg::OP_PUSH;
		req_ch.value  = '0;
		idle_run      = 0;
		burst_left    = 0;
		fill_level    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pop, signed extremes, ties, drain past empty
		send_word(hpq_pkg::OP_POP, 32'h1234_5678);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0000);
		send_word(hpq_pkg::OP_PUSH, 32'h7FFF_FFFF);
		send_word(hpq_pkg::OP_PUSH, 32'h8000_0000);
		send_word(hpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0001);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0005);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0005);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0005);
		repeat (9) send_word(hpq_pkg::OP_POP, 32'hFFFF_FFFF);
		send_word(hpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_word(hpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_word(hpq_pkg::OP_POP, 32'h0);
		send_word(hpq_pkg::OP_PUSH, 32'h0000_0001);
		repeat (3) send_word(hpq_pkg::OP_POP, 32'h0);
		drain_all();

		// random mix; the trend shifts so the occupancy wanders up and down
		trend = TR_EVEN;
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n % 48 == 0)
				trend = trend_t'($urandom_range(0, 2));
			pct_push = (trend == TR_GROW) ? 70 : (trend == TR_SHRINK) ? 30 : 50;
			op = ($urandom_range(1, 100) <= pct_push) ? hpq_pkg::OP_PUSH : hpq_pkg::OP_POP;
			send_word(op, op == hpq_pkg::OP_PUSH ? pick_value() : hpq_pkg::data_t'($urandom));
		end
		drain_all();

		// empty it out completely, then knock on the empty heap
		while (fill_level > 0)
			send_word(hpq_pkg::OP_POP, hpq_pkg::data_t'($urandom));
		repeat (2) send_word(hpq_pkg::OP_POP, hpq_pkg::data_t'($urandom));
		drain_all();

		if (chk_fails == 0 && chk_outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
